// File: design/hmbr_pkg.sv
// Shared types and constants of the handheld memory bus router.
// Used by rtr front, queue, back and the top level; depends on nothing.
package hmbr_pkg;

   // Default memory sizes in bytes
   localparam int LARGE_RAM_BYTES_DEF = 262144;
   localparam int SMALL_RAM_BYTES_DEF = 32768;
   localparam int SAVE_RAM_BYTES_DEF  = 65536;

   // Fixed memories, in 32-bit words
   localparam int PAL_WORDS = 256;
   localparam int VID_WORDS = 24576;
   localparam int OBJ_WORDS = 256;

   localparam int ROM_LEN_W = 26;
   localparam int OFF_W     = 25;
   localparam int QUEUE_DEPTH = 2;

   // Constant modulo by reciprocal: quotient estimate = (x * (2^MOD_K / M)) >> MOD_K
   localparam int MOD_K   = 28;
   localparam int MOD_W   = 19;
   localparam int MOD_R_W = 20;

   // Address map constants
   localparam logic [31:0] BOOT_LIMIT  = 32'h0000_4000;
   localparam logic [31:0] IO_MASK     = 32'h0000_03FF;
   localparam logic [31:0] ROM_MASK    = 32'h01FF_FFFF;
   localparam logic [16:0] VID_MASK    = 17'h1FFFF;
   localparam logic [16:0] VID_TOP     = 17'h18000;
   localparam logic [16:0] VID_MIRROR  = 17'h17FFF;
   localparam logic [16:0] VID_OBJ_BASE = 17'h10000;

   // Region codes (top address byte)
   localparam logic [7:0] RG_BOOT  = 8'h00;
   localparam logic [7:0] RG_LARGE = 8'h02;
   localparam logic [7:0] RG_SMALL = 8'h03;
   localparam logic [7:0] RG_IO    = 8'h04;
   localparam logic [7:0] RG_PAL   = 8'h05;
   localparam logic [7:0] RG_VID   = 8'h06;
   localparam logic [7:0] RG_OBJ   = 8'h07;
   localparam logic [7:0] RG_ROM0  = 8'h08;
   localparam logic [7:0] RG_ROM1  = 8'h09;
   localparam logic [7:0] RG_ROM2  = 8'h0A;
   localparam logic [7:0] RG_ROM3  = 8'h0B;
   localparam logic [7:0] RG_ROM4  = 8'h0C;
   localparam logic [7:0] RG_READY = 8'h0D;
   localparam logic [7:0] RG_SAVE0 = 8'h0E;
   localparam logic [7:0] RG_SAVE1 = 8'h0F;

   // Opcodes
   localparam logic [2:0] OP_RD_WORD = 3'd2;
   localparam logic [2:0] OP_WR_BYTE = 3'd3;
   localparam logic [2:0] OP_WR_WORD = 3'd5;

   // Access sizes
   localparam logic [1:0] SZ_BYTE = 2'd0;
   localparam logic [1:0] SZ_HALF = 2'd1;
   localparam logic [1:0] SZ_WORD = 2'd2;

   // Forward targets
   localparam logic [1:0] TGT_INSIDE = 2'd0;
   localparam logic [1:0] TGT_BOOT   = 2'd1;
   localparam logic [1:0] TGT_ROM    = 2'd2;
   localparam logic [1:0] TGT_IO     = 2'd3;

   // Transaction classes decided by the front
   localparam logic [3:0] K_NONE  = 4'd0;
   localparam logic [3:0] K_ONE   = 4'd1;
   localparam logic [3:0] K_BOOT  = 4'd2;
   localparam logic [3:0] K_IO    = 4'd3;
   localparam logic [3:0] K_ROM   = 4'd4;
   localparam logic [3:0] K_LARGE = 4'd5;
   localparam logic [3:0] K_SMALL = 4'd6;
   localparam logic [3:0] K_PAL   = 4'd7;
   localparam logic [3:0] K_VID   = 4'd8;
   localparam logic [3:0] K_OBJ   = 4'd9;
   localparam logic [3:0] K_SAVE  = 4'd10;

   typedef struct packed {
      logic [3:0]       kind;
      logic             wr;
      logic [1:0]       sz;
      logic [2:0]       op;
      logic [OFF_W-1:0] off;
      logic [31:0]      data;
   } entry_type;

endpackage

// File: design/hmbr_front.sv
// Front of the router: accepts bus transactions, decodes region and size,
// and reduces RAM offsets modulo the RAM sizes. Depends on hmbr_pkg.
module hmbr_front #(
   parameter int LARGE_RAM_BYTES = hmbr_pkg::LARGE_RAM_BYTES_DEF,
   parameter int SMALL_RAM_BYTES = hmbr_pkg::SMALL_RAM_BYTES_DEF,
   parameter int SAVE_RAM_BYTES  = hmbr_pkg::SAVE_RAM_BYTES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [2:0]          req_opcode,
   input  logic [31:0]         req_address,
   input  logic [31:0]         req_write_data,
   input  logic                clear_busy,
   output logic                out_valid,
   input  logic                out_ready,
   output hmbr_pkg::entry_type out_entry
);

   localparam int R_L = (1 << hmbr_pkg::MOD_K) / LARGE_RAM_BYTES;
   localparam int R_S = (1 << hmbr_pkg::MOD_K) / SMALL_RAM_BYTES;
   localparam int R_V = (1 << hmbr_pkg::MOD_K) / SAVE_RAM_BYTES;
   localparam int MW  = hmbr_pkg::MOD_W;
   localparam int RW  = hmbr_pkg::MOD_R_W;
   localparam int XW  = hmbr_pkg::MOD_K;
   localparam int PW  = XW + MW;

   logic en;
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   hmbr_pkg::entry_type ent1_in, ent1_ff, ent2_ff, ent3_ff, ent4_in, ent4_ff;
   logic [XW-1:0] x1_ff, x2_ff, x3_ff;
   logic [MW-1:0] q2_in, q2_ff;
   logic [XW-1:0] qm3_in, qm3_ff;

   // Stage 1 decode
   logic        wr;
   logic [1:0]  sz;
   logic [31:0] a;
   logic [31:0] wd_m;
   logic [31:0] wd_rep;
   logic [16:0] vo;

   always_comb begin
      wr = req_opcode >= hmbr_pkg::OP_WR_BYTE;
      sz = wr ? 2'(req_opcode - hmbr_pkg::OP_WR_BYTE) : req_opcode[1:0];
      a  = req_address;
      case (sz)
         hmbr_pkg::SZ_BYTE: begin
            wd_m   = {24'd0, req_write_data[7:0]};
            wd_rep = {4{req_write_data[7:0]}};
         end
         hmbr_pkg::SZ_HALF: begin
            a[0]   = 1'b0;
            wd_m   = {16'd0, req_write_data[15:0]};
            wd_rep = {2{req_write_data[15:0]}};
         end
         default: begin
            a[1:0] = 2'b00;
            wd_m   = req_write_data;
            wd_rep = req_write_data;
         end
      endcase
      vo = a[16:0] & hmbr_pkg::VID_MASK;
      if (vo >= hmbr_pkg::VID_TOP) begin
         vo = vo & hmbr_pkg::VID_MIRROR;
      end

      ent1_in.wr   = wr;
      ent1_in.sz   = sz;
      ent1_in.op   = req_opcode;
      ent1_in.off  = '0;
      ent1_in.data = wd_rep;
      ent1_in.kind = hmbr_pkg::K_NONE;
      if (req_opcode <= hmbr_pkg::OP_WR_WORD) begin
         case (a[31:24])
            hmbr_pkg::RG_BOOT: begin
               if (!wr && a < hmbr_pkg::BOOT_LIMIT) begin
                  ent1_in.kind = hmbr_pkg::K_BOOT;
                  ent1_in.off  = a[hmbr_pkg::OFF_W-1:0];
               end
            end
            hmbr_pkg::RG_LARGE: ent1_in.kind = hmbr_pkg::K_LARGE;
            hmbr_pkg::RG_SMALL: ent1_in.kind = hmbr_pkg::K_SMALL;
            hmbr_pkg::RG_IO: begin
               ent1_in.kind = hmbr_pkg::K_IO;
               ent1_in.off  = hmbr_pkg::OFF_W'(a & hmbr_pkg::IO_MASK);
               ent1_in.data = wr ? wd_m : 32'd0;
            end
            hmbr_pkg::RG_PAL: begin
               ent1_in.kind = hmbr_pkg::K_PAL;
               ent1_in.off  = hmbr_pkg::OFF_W'(a & hmbr_pkg::IO_MASK);
            end
            hmbr_pkg::RG_VID: begin
               // byte writes into object video RAM are dropped
               if (!(wr && sz == hmbr_pkg::SZ_BYTE && vo >= hmbr_pkg::VID_OBJ_BASE)) begin
                  ent1_in.kind = hmbr_pkg::K_VID;
               end
               ent1_in.off = hmbr_pkg::OFF_W'(vo);
            end
            hmbr_pkg::RG_OBJ: begin
               if (!(wr && sz == hmbr_pkg::SZ_BYTE)) begin
                  ent1_in.kind = hmbr_pkg::K_OBJ;
               end
               ent1_in.off = hmbr_pkg::OFF_W'(a & hmbr_pkg::IO_MASK);
            end
            hmbr_pkg::RG_ROM0, hmbr_pkg::RG_ROM1, hmbr_pkg::RG_ROM2,
            hmbr_pkg::RG_ROM3, hmbr_pkg::RG_ROM4: begin
               if (!wr) begin
                  ent1_in.kind = hmbr_pkg::K_ROM;
                  ent1_in.off  = hmbr_pkg::OFF_W'(a & hmbr_pkg::ROM_MASK);
               end
            end
            hmbr_pkg::RG_SAVE0, hmbr_pkg::RG_SAVE1: ent1_in.kind = hmbr_pkg::K_SAVE;
            default: begin
               if (!wr) begin
                  ent1_in.kind = hmbr_pkg::K_ONE;
               end
            end
         endcase
      end
   end

   // Stage 2: quotient estimate
   logic [MW-1:0] r_sel;
   logic [PW-1:0] prod2;

   always_comb begin
      case (ent1_ff.kind)
         hmbr_pkg::K_LARGE: r_sel = MW'(R_L);
         hmbr_pkg::K_SMALL: r_sel = MW'(R_S);
         default:           r_sel = MW'(R_V);
      endcase
      prod2 = PW'(x1_ff) * PW'(r_sel);
      q2_in = prod2[PW-1:XW];
   end

   // Stage 3: quotient times modulus
   logic [MW-1:0]   m3_sel;
   logic [2*MW-1:0] prod3;

   always_comb begin
      case (ent2_ff.kind)
         hmbr_pkg::K_LARGE: m3_sel = MW'(LARGE_RAM_BYTES);
         hmbr_pkg::K_SMALL: m3_sel = MW'(SMALL_RAM_BYTES);
         default:           m3_sel = MW'(SAVE_RAM_BYTES);
      endcase
      prod3  = (2*MW)'(q2_ff) * (2*MW)'(m3_sel);
      qm3_in = prod3[XW-1:0];
   end

   // Stage 4: remainder with one correction, then re-align
   logic [MW-1:0] m4_sel;
   logic [XW-1:0] diff4;
   logic [RW-1:0] rem4;

   always_comb begin
      case (ent3_ff.kind)
         hmbr_pkg::K_LARGE: m4_sel = MW'(LARGE_RAM_BYTES);
         hmbr_pkg::K_SMALL: m4_sel = MW'(SMALL_RAM_BYTES);
         default:           m4_sel = MW'(SAVE_RAM_BYTES);
      endcase
      diff4 = x3_ff - qm3_ff;
      rem4  = diff4[RW-1:0];
      if (rem4 >= RW'(m4_sel)) begin
         rem4 = rem4 - RW'(m4_sel);
      end
      ent4_in = ent3_ff;
      if (ent3_ff.kind == hmbr_pkg::K_LARGE || ent3_ff.kind == hmbr_pkg::K_SMALL) begin
         if (ent3_ff.sz == hmbr_pkg::SZ_HALF) begin
            rem4[0] = 1'b0;
         end else if (ent3_ff.sz == hmbr_pkg::SZ_WORD) begin
            rem4[1:0] = 2'b00;
         end
         ent4_in.off = hmbr_pkg::OFF_W'(rem4);
      end else if (ent3_ff.kind == hmbr_pkg::K_SAVE) begin
         ent4_in.off = hmbr_pkg::OFF_W'(rem4);
      end
   end

   assign en        = !v4_ff || out_ready;
   assign req_ready = en && !clear_busy;
   assign out_valid = v4_ff;
   assign out_entry = ent4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid && req_ready;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ent1_ff <= ent1_in;
         x1_ff   <= a[XW-1:0];
         ent2_ff <= ent1_ff;
         x2_ff   <= x1_ff;
         q2_ff   <= q2_in;
         ent3_ff <= ent2_ff;
         x3_ff   <= x2_ff;
         qm3_ff  <= qm3_in;
         ent4_ff <= ent4_in;
      end
   end

endmodule

// File: design/hmbr_queue.sv
// Two-entry queue between the router front and back.
// Depends on hmbr_pkg for the entry type.
module hmbr_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  hmbr_pkg::entry_type in_entry,
   output logic                out_valid,
   input  logic                out_ready,
   output hmbr_pkg::entry_type out_entry
);

   localparam int PTR_W = $clog2(hmbr_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(hmbr_pkg::QUEUE_DEPTH + 1);

   hmbr_pkg::entry_type slot_mem [hmbr_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic push, pop;

   assign in_ready  = count_ff != CNT_W'(hmbr_pkg::QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_entry = slot_mem[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(hmbr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(hmbr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_mem[wr_ptr_ff] <= in_entry;
      end
   end

endmodule

// File: design/hmbr_back.sv
// Back of the router: owns the RAMs, runs the cartridge ROM remainder unit
// and holds the result register. Depends on hmbr_pkg.
module hmbr_back #(
   parameter int LARGE_RAM_BYTES = hmbr_pkg::LARGE_RAM_BYTES_DEF,
   parameter int SMALL_RAM_BYTES = hmbr_pkg::SMALL_RAM_BYTES_DEF,
   parameter int SAVE_RAM_BYTES  = hmbr_pkg::SAVE_RAM_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  hmbr_pkg::entry_type           in_entry,
   input  logic [hmbr_pkg::ROM_LEN_W-1:0] rom_length,
   output logic                          clear_busy,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [31:0]                   rsp_read_data,
   output logic [1:0]                    rsp_forward_target,
   output logic [hmbr_pkg::OFF_W-1:0]    rsp_forward_offset,
   output logic [2:0]                    rsp_forward_opcode,
   output logic [31:0]                   rsp_forward_data,
   output logic                          rsp_save_dirty
);

   localparam int LARGE_WORDS = (LARGE_RAM_BYTES + 3) / 4;
   localparam int SMALL_WORDS = (SMALL_RAM_BYTES + 3) / 4;
   localparam int LARGE_REM   = LARGE_RAM_BYTES % 4;
   localparam int SMALL_REM   = SMALL_RAM_BYTES % 4;
   localparam int LW  = $clog2(LARGE_WORDS);
   localparam int SW  = $clog2(SMALL_WORDS);
   localparam int PW  = $clog2(hmbr_pkg::PAL_WORDS);
   localparam int VW  = $clog2(hmbr_pkg::VID_WORDS);
   localparam int OW  = $clog2(hmbr_pkg::OBJ_WORDS);
   localparam int BW  = $clog2(SAVE_RAM_BYTES);
   localparam int MAX_A = (LARGE_WORDS > SMALL_WORDS) ? LARGE_WORDS : SMALL_WORDS;
   localparam int MAX_B = (MAX_A > hmbr_pkg::VID_WORDS) ? MAX_A : hmbr_pkg::VID_WORDS;
   localparam int MAX_D = (MAX_B > SAVE_RAM_BYTES) ? MAX_B : SAVE_RAM_BYTES;
   localparam int CW    = $clog2(MAX_D);
   localparam int OFF_W = hmbr_pkg::OFF_W;
   localparam int RLW   = hmbr_pkg::ROM_LEN_W;
   localparam int DCW   = $clog2(OFF_W);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_READ  = 2'd2;
   localparam logic [1:0] ST_DIV   = 2'd3;

   logic [31:0] large_mem [LARGE_WORDS];
   logic [31:0] small_mem [SMALL_WORDS];
   logic [31:0] pal_mem   [hmbr_pkg::PAL_WORDS];
   logic [31:0] vid_mem   [hmbr_pkg::VID_WORDS];
   logic [31:0] obj_mem   [hmbr_pkg::OBJ_WORDS];
   logic [7:0]  save_mem  [SAVE_RAM_BYTES];

   logic [31:0] large_rd_ff, small_rd_ff, pal_rd_ff, vid_rd_ff, obj_rd_ff;
   logic [7:0]  save_rd_ff;

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] clr_ff, clr_in;
   logic          save_written_ff, save_written_in;
   logic          clearing, pop, out_free;

   logic [3:0]       cur_kind_ff;
   logic [1:0]       cur_sz_ff;
   logic [1:0]       cur_lo_ff;
   logic [2:0]       cur_op_ff;
   logic [3:0]       cur_ok_ff;
   logic [RLW-1:0]   div_rem_ff, div_rem_in, div_t;
   logic [OFF_W-1:0] div_num_ff, div_num_in;
   logic [DCW-1:0]   div_cnt_ff, div_cnt_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [31:0]      rsp_read_data_ff;
   logic [1:0]       rsp_forward_target_ff;
   logic [OFF_W-1:0] rsp_forward_offset_ff;
   logic [2:0]       rsp_forward_opcode_ff;
   logic [31:0]      rsp_forward_data_ff;
   logic             rsp_save_dirty_ff;

   logic             out_load;
   logic [31:0]      o_rdata, o_fdata;
   logic [1:0]       o_target;
   logic [OFF_W-1:0] o_off;
   logic [2:0]       o_op;

   // Pick the addressed byte lanes and move them down to bit 0
   function automatic logic [31:0] lane_extract(input logic [31:0] word,
                                                input logic [3:0] ok,
                                                input logic [1:0] sz,
                                                input logic [1:0] lo);
      logic [31:0] w;
      w = word & {{8{ok[3]}}, {8{ok[2]}}, {8{ok[1]}}, {8{ok[0]}}};
      case (sz)
         hmbr_pkg::SZ_BYTE: lane_extract = {24'd0, 8'(w >> {lo, 3'b000})};
         hmbr_pkg::SZ_HALF: lane_extract = {16'd0, lo[1] ? w[31:16] : w[15:0]};
         default:           lane_extract = w;
      endcase
   endfunction

   assign clearing   = state_ff == ST_CLEAR;
   assign clear_busy = clearing;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign pop        = (state_ff == ST_IDLE) && in_valid && out_free;
   assign in_ready   = pop;

   // Byte lane write mask and lanes past the end of odd-sized RAMs
   logic [3:0] be_op, ok_l, ok_s, ok_cur;
   logic       pair;

   always_comb begin
      pair = (in_entry.kind == hmbr_pkg::K_PAL || in_entry.kind == hmbr_pkg::K_VID) &&
             in_entry.sz == hmbr_pkg::SZ_BYTE;
      case (in_entry.sz)
         hmbr_pkg::SZ_BYTE: be_op = 4'b0001 << in_entry.off[1:0];
         hmbr_pkg::SZ_HALF: be_op = in_entry.off[1] ? 4'b1100 : 4'b0011;
         default:           be_op = 4'b1111;
      endcase
      if (pair) begin
         be_op = in_entry.off[1] ? 4'b1100 : 4'b0011;
      end
      for (int i = 0; i < 4; i++) begin
         ok_l[i] = (LARGE_REM == 0) || (i < LARGE_REM) ||
                   (in_entry.off[LW+1:2] != LW'(LARGE_WORDS - 1));
         ok_s[i] = (SMALL_REM == 0) || (i < SMALL_REM) ||
                   (in_entry.off[SW+1:2] != SW'(SMALL_WORDS - 1));
      end
      case (in_entry.kind)
         hmbr_pkg::K_LARGE: ok_cur = ok_l;
         hmbr_pkg::K_SMALL: ok_cur = ok_s;
         default:           ok_cur = 4'hF;
      endcase
   end

   // Memory port controls: the clearing sweep owns the ports after reset
   logic [31:0] mem_wdata;
   logic        op_wr;
   logic        large_we, small_we, pal_we, vid_we, obj_we, save_we;
   logic [3:0]  large_be, small_be, pal_be, vid_be, obj_be;
   logic [LW-1:0] large_idx;
   logic [SW-1:0] small_idx;
   logic [PW-1:0] pal_idx;
   logic [VW-1:0] vid_idx;
   logic [OW-1:0] obj_idx;
   logic [BW-1:0] save_idx;
   logic [7:0]    save_wdata;

   always_comb begin
      op_wr      = pop && in_entry.wr;
      mem_wdata  = clearing ? 32'd0 : in_entry.data;
      save_wdata = clearing ? 8'd0 : in_entry.data[7:0];
      if (clearing) begin
         large_we  = {1'b0, clr_ff} < (CW+1)'(LARGE_WORDS);
         small_we  = {1'b0, clr_ff} < (CW+1)'(SMALL_WORDS);
         pal_we    = {1'b0, clr_ff} < (CW+1)'(hmbr_pkg::PAL_WORDS);
         vid_we    = {1'b0, clr_ff} < (CW+1)'(hmbr_pkg::VID_WORDS);
         obj_we    = {1'b0, clr_ff} < (CW+1)'(hmbr_pkg::OBJ_WORDS);
         save_we   = {1'b0, clr_ff} < (CW+1)'(SAVE_RAM_BYTES);
         large_be  = 4'hF;
         small_be  = 4'hF;
         pal_be    = 4'hF;
         vid_be    = 4'hF;
         obj_be    = 4'hF;
         large_idx = clr_ff[LW-1:0];
         small_idx = clr_ff[SW-1:0];
         pal_idx   = clr_ff[PW-1:0];
         vid_idx   = clr_ff[VW-1:0];
         obj_idx   = clr_ff[OW-1:0];
         save_idx  = clr_ff[BW-1:0];
      end else begin
         large_we  = op_wr && in_entry.kind == hmbr_pkg::K_LARGE;
         small_we  = op_wr && in_entry.kind == hmbr_pkg::K_SMALL;
         pal_we    = op_wr && in_entry.kind == hmbr_pkg::K_PAL;
         vid_we    = op_wr && in_entry.kind == hmbr_pkg::K_VID;
         obj_we    = op_wr && in_entry.kind == hmbr_pkg::K_OBJ;
         save_we   = op_wr && in_entry.kind == hmbr_pkg::K_SAVE;
         large_be  = be_op & ok_l;
         small_be  = be_op & ok_s;
         pal_be    = be_op;
         vid_be    = be_op;
         obj_be    = be_op;
         large_idx = in_entry.off[LW+1:2];
         small_idx = in_entry.off[SW+1:2];
         pal_idx   = in_entry.off[PW+1:2];
         vid_idx   = in_entry.off[VW+1:2];
         obj_idx   = in_entry.off[OW+1:2];
         save_idx  = in_entry.off[BW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         if (large_we && large_be[i]) begin
            large_mem[large_idx][8*i +: 8] <= mem_wdata[8*i +: 8];
         end
      end
      large_rd_ff <= large_mem[large_idx];
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         if (small_we && small_be[i]) begin
            small_mem[small_idx][8*i +: 8] <= mem_wdata[8*i +: 8];
         end
      end
      small_rd_ff <= small_mem[small_idx];
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         if (pal_we && pal_be[i]) begin
            pal_mem[pal_idx][8*i +: 8] <= mem_wdata[8*i +: 8];
         end
      end
      pal_rd_ff <= pal_mem[pal_idx];
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         if (vid_we && vid_be[i]) begin
            vid_mem[vid_idx][8*i +: 8] <= mem_wdata[8*i +: 8];
         end
      end
      vid_rd_ff <= vid_mem[vid_idx];
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         if (obj_we && obj_be[i]) begin
            obj_mem[obj_idx][8*i +: 8] <= mem_wdata[8*i +: 8];
         end
      end
      obj_rd_ff <= obj_mem[obj_idx];
   end

   always_ff @(posedge clock) begin
      if (save_we) begin
         save_mem[save_idx] <= save_wdata;
      end
      save_rd_ff <= save_mem[save_idx];
   end

   // One remainder bit per cycle: shift in the next dividend bit, subtract if it fits
   always_comb begin
      div_t = {div_rem_ff[RLW-2:0], div_num_ff[OFF_W-1]};
      if (div_t >= rom_length) begin
         div_t = div_t - rom_length;
      end
   end

   logic [31:0] rd_word;

   always_comb begin
      case (cur_kind_ff)
         hmbr_pkg::K_LARGE: rd_word = large_rd_ff;
         hmbr_pkg::K_SMALL: rd_word = small_rd_ff;
         hmbr_pkg::K_PAL:   rd_word = pal_rd_ff;
         hmbr_pkg::K_VID:   rd_word = vid_rd_ff;
         hmbr_pkg::K_OBJ:   rd_word = obj_rd_ff;
         default:           rd_word = 32'd0;
      endcase
   end

   always_comb begin
      state_in        = state_ff;
      clr_in          = clr_ff;
      save_written_in = save_written_ff;
      div_rem_in      = div_rem_ff;
      div_num_in      = div_num_ff;
      div_cnt_in      = div_cnt_ff;
      out_load        = 1'b0;
      o_rdata         = 32'd0;
      o_target        = hmbr_pkg::TGT_INSIDE;
      o_off           = '0;
      o_op            = 3'd0;
      o_fdata         = 32'd0;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CW'(MAX_D - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (pop) begin
               case (in_entry.kind)
                  hmbr_pkg::K_ONE: begin
                     out_load = 1'b1;
                     o_rdata  = 32'd1;
                  end
                  hmbr_pkg::K_BOOT: begin
                     out_load = 1'b1;
                     o_target = hmbr_pkg::TGT_BOOT;
                     o_off    = in_entry.off;
                     o_op     = in_entry.op;
                  end
                  hmbr_pkg::K_IO: begin
                     out_load = 1'b1;
                     o_target = hmbr_pkg::TGT_IO;
                     o_off    = in_entry.off;
                     o_op     = in_entry.op;
                     o_fdata  = in_entry.data;
                  end
                  hmbr_pkg::K_ROM: begin
                     if (rom_length == '0) begin
                        out_load = 1'b1;
                     end else begin
                        state_in   = ST_DIV;
                        div_rem_in = '0;
                        div_num_in = in_entry.off;
                        div_cnt_in = '0;
                     end
                  end
                  hmbr_pkg::K_LARGE, hmbr_pkg::K_SMALL, hmbr_pkg::K_PAL,
                  hmbr_pkg::K_VID, hmbr_pkg::K_OBJ, hmbr_pkg::K_SAVE: begin
                     if (in_entry.wr) begin
                        out_load = 1'b1;
                        if (in_entry.kind == hmbr_pkg::K_SAVE) begin
                           save_written_in = 1'b1;
                        end
                     end else begin
                        state_in = ST_READ;
                     end
                  end
                  default: out_load = 1'b1;
               endcase
            end
         end
         ST_READ: begin
            out_load = 1'b1;
            state_in = ST_IDLE;
            if (cur_kind_ff == hmbr_pkg::K_SAVE) begin
               case (cur_sz_ff)
                  hmbr_pkg::SZ_BYTE: o_rdata = {24'd0, save_rd_ff};
                  hmbr_pkg::SZ_HALF: o_rdata = {16'd0, {2{save_rd_ff}}};
                  default:           o_rdata = {4{save_rd_ff}};
               endcase
            end else begin
               o_rdata = lane_extract(rd_word, cur_ok_ff, cur_sz_ff, cur_lo_ff);
            end
         end
         ST_DIV: begin
            div_rem_in = div_t;
            div_num_in = div_num_ff << 1;
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DCW'(OFF_W - 1)) begin
               out_load = 1'b1;
               o_target = hmbr_pkg::TGT_ROM;
               o_off    = div_t[OFF_W-1:0];
               o_op     = cur_op_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clr_ff          <= '0;
         save_written_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         clr_ff          <= clr_in;
         save_written_ff <= save_written_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      div_rem_ff <= div_rem_in;
      div_num_ff <= div_num_in;
      div_cnt_ff <= div_cnt_in;
      if (pop) begin
         cur_kind_ff <= in_entry.kind;
         cur_sz_ff   <= in_entry.sz;
         cur_lo_ff   <= in_entry.off[1:0];
         cur_op_ff   <= in_entry.op;
         cur_ok_ff   <= ok_cur;
      end
      if (out_load) begin
         rsp_read_data_ff      <= o_rdata;
         rsp_forward_target_ff <= o_target;
         rsp_forward_offset_ff <= o_off;
         rsp_forward_opcode_ff <= o_op;
         rsp_forward_data_ff   <= o_fdata;
         rsp_save_dirty_ff     <= save_written_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_data      = rsp_read_data_ff;
   assign rsp_forward_target = rsp_forward_target_ff;
   assign rsp_forward_offset = rsp_forward_offset_ff;
   assign rsp_forward_opcode = rsp_forward_opcode_ff;
   assign rsp_forward_data   = rsp_forward_data_ff;
   assign rsp_save_dirty     = rsp_save_dirty_ff;

   a_pop_out_free: assert property (@(posedge clock) disable iff (reset)
      pop |-> out_free)
      else $error("transaction taken while the result register is occupied");

   a_read_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> rsp_valid_ff)
      else $error("memory read finished without a result");

   a_clear_no_pop: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !pop)
      else $error("transaction taken during the clearing sweep");

   a_dirty_sticky: assert property (@(posedge clock) disable iff (reset)
      save_written_ff |=> save_written_ff)
      else $error("save dirty flag dropped");

endmodule

// File: design/handheld_memory_bus_router_top.sv
// Top level of the handheld memory bus router: configuration register,
// front decoder, queue and back end. Depends on hmbr_pkg and the hmbr modules.
//
// After reset the block sweeps all internal RAMs to zero, one word (save RAM:
// one byte) per cycle, until the sweep has covered every entry of the deepest
// store; req_ready stays low until the sweep ends. A transaction then passes
// a four-stage front (decode and reduction of RAM offsets by a reciprocal
// multiply) and a two-entry queue. The back end retires writes, forwarded and
// constant transactions straight from its idle state, internal RAM reads
// through a read state (the read port is registered), and cartridge ROM reads,
// while the ROM length is not zero, through the remainder unit that produces
// one offset bit per cycle. Results leave through a register, so the back end
// takes the next transaction in the cycle that the waiting result is taken.
module handheld_memory_bus_router_top #(
   parameter int LARGE_RAM_BYTES = hmbr_pkg::LARGE_RAM_BYTES_DEF,
   parameter int SMALL_RAM_BYTES = hmbr_pkg::SMALL_RAM_BYTES_DEF,
   parameter int SAVE_RAM_BYTES  = hmbr_pkg::SAVE_RAM_BYTES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [hmbr_pkg::ROM_LEN_W-1:0] csr_data,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [2:0]                     req_opcode,
   input  logic [31:0]                    req_address,
   input  logic [31:0]                    req_write_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [31:0]                    rsp_read_data,
   output logic [1:0]                     rsp_forward_target,
   output logic [hmbr_pkg::OFF_W-1:0]     rsp_forward_offset,
   output logic [2:0]                     rsp_forward_opcode,
   output logic [31:0]                    rsp_forward_data,
   output logic                           rsp_save_dirty
);

   logic [hmbr_pkg::ROM_LEN_W-1:0] rom_length_ff;
   logic                clear_busy;
   logic                f_valid, f_ready, b_valid, b_ready;
   hmbr_pkg::entry_type f_entry, b_entry;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_length_ff <= '0;
      end else if (csr_valid) begin
         rom_length_ff <= csr_data;
      end
   end

   hmbr_front #(
      .LARGE_RAM_BYTES (LARGE_RAM_BYTES),
      .SMALL_RAM_BYTES (SMALL_RAM_BYTES),
      .SAVE_RAM_BYTES  (SAVE_RAM_BYTES)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_address    (req_address),
      .req_write_data (req_write_data),
      .clear_busy     (clear_busy),
      .out_valid      (f_valid),
      .out_ready      (f_ready),
      .out_entry      (f_entry)
   );

   hmbr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_entry  (f_entry),
      .out_valid (b_valid),
      .out_ready (b_ready),
      .out_entry (b_entry)
   );

   hmbr_back #(
      .LARGE_RAM_BYTES (LARGE_RAM_BYTES),
      .SMALL_RAM_BYTES (SMALL_RAM_BYTES),
      .SAVE_RAM_BYTES  (SAVE_RAM_BYTES)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .in_valid           (b_valid),
      .in_ready           (b_ready),
      .in_entry           (b_entry),
      .rom_length         (rom_length_ff),
      .clear_busy         (clear_busy),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_read_data      (rsp_read_data),
      .rsp_forward_target (rsp_forward_target),
      .rsp_forward_offset (rsp_forward_offset),
      .rsp_forward_opcode (rsp_forward_opcode),
      .rsp_forward_data   (rsp_forward_data),
      .rsp_save_dirty     (rsp_save_dirty)
   );

endmodule
